FILE: src/brq_pkg.sv
// ----------------------------------------------------------------------------
// brq_pkg - bounded ready queue shared definitions
// Command and status codes, the cell search modes and the cell control types.
// ----------------------------------------------------------------------------
`default_nettype none

package brq_pkg;

  // command codes
  localparam logic [2:0] CmdPushTail   = 3'd0;
  localparam logic [2:0] CmdPushSorted = 3'd1;
  localparam logic [2:0] CmdPop        = 3'd2;
  localparam logic [2:0] CmdTop        = 3'd3;
  localparam logic [2:0] CmdRemove     = 3'd4;
  localparam logic [2:0] CmdCount     = 3'd5;

  // status codes
  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic [4:0] CapacityReset = 5'd16;

  // what each cell looks for during a search
  typedef enum logic [1:0] {
    SrchTail   = 2'd0,  // first free slot
    SrchSorted = 2'd1,  // first free slot or first larger priority
    SrchHead   = 2'd2,  // first held slot
    SrchId     = 2'd3   // first held slot with matching id
  } srch_e;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } entry_t;

  // search chain link between neighbor cells
  typedef struct packed {
    logic   found;
    entry_t ent;
  } link_t;

  // broadcast control to every cell
  typedef struct packed {
    srch_e  mode;
    logic   do_ins;
    logic   do_del;
    entry_t ent;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/brq_cell.sv
// ----------------------------------------------------------------------------
// brq_cell - one slot of the bounded ready queue
// Holds one entry, takes part in the search chain and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module brq_cell
  import brq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire entry_t           left_i,
  input  wire entry_t           right_i,
  input  wire link_t            link_i,
  output      link_t            link_o,
  output      entry_t           ent_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  entry_t ent_q;
  logic   occ;
  logic   hit;

  always_comb begin
    occ = (count_i > MyIdx);
    case (ctrl_i.mode)
      SrchTail:   hit = !occ;
      SrchSorted: hit = !occ || (ent_q.prio > ctrl_i.ent.prio);
      SrchHead:   hit = occ;
      SrchId:     hit = occ && (ent_q.id == ctrl_i.ent.id);
      default:    hit = 1'b0;
    endcase
  end

  // first hit wins, later cells only pass it on
  assign link_o.found = link_i.found | hit;
  assign link_o.ent   = link_i.found ? link_i.ent : (hit ? ent_q : '0);
  assign ent_o        = ent_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_ins) begin
      if (link_i.found) begin
        ent_q <= left_i;
      end else if (hit) begin
        ent_q <= ctrl_i.ent;
      end
    end else if (ctrl_i.do_del && (link_i.found || hit)) begin
      ent_q <= right_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/bounded_ready_queue_core.sv
// ----------------------------------------------------------------------------
// bounded_ready_queue_core - bounded priority queue with fifo order on ties
// Row of slot cells with a search chain; push, sorted push, pop, top, remove.
// ----------------------------------------------------------------------------
// Each command is searched and applied in the cycle it is accepted, and its
// result is loaded into the output register. The clock period is set by the
// search chain, which ripples from the head cell through all MAX_ENTRIES
// cells and then gates the shift enable of every cell. A new item is accepted
// whenever the output register is empty or its result is taken in the same
// cycle. Entries are head first in the cell row; inserts shift later cells
// one slot back, deletes pull them one slot forward. Slot contents are not
// reset, only the fill count, the capacity and the output valid flag are.
`default_nettype none

module bounded_ready_queue_core
  import brq_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // config
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  // command items
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [2:0] cmd_i,
  input  wire logic [7:0] entry_id_i,
  input  wire logic [7:0] entry_priority_i,
  // result items
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [1:0] status_o,
  output      logic [7:0] out_id_o,
  output      logic [7:0] out_priority_o,
  output      logic [4:0] fill_count_o
);

  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int LimW = (CntW > 5) ? CntW : 5;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

  logic [4:0]      capacity_q;
  logic [CntW-1:0] count_q, count_d;

  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  entry_t          res_q, res_d;
  logic [4:0]      fill_q;

  logic            accept;
  logic            full;
  logic            empty;
  logic            is_ins;
  logic            ins_ok;
  logic            del_ok;
  cell_ctrl_t      ctrl;

  // chain links, link[0] feeds the head cell
  link_t           link [MAX_ENTRIES+1];
  entry_t          ents [MAX_ENTRIES];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // limit is the smaller of capacity and the cell count
  assign full  = (LimW'(count_q) >= LimW'(capacity_q)) || (count_q == MaxCnt);
  assign empty = (count_q == '0);

  assign is_ins = (cmd_i == CmdPushTail) || (cmd_i == CmdPushSorted);
  assign ins_ok = is_ins && !full;

  // a pop needs any entry, a remove needs a match out of the chain
  always_comb begin
    del_ok = 1'b0;
    if (cmd_i == CmdPop) begin
      del_ok = !empty;
    end else if (cmd_i == CmdRemove) begin
      del_ok = link[MAX_ENTRIES].found;
    end
  end

  // search mode decode
  always_comb begin
    ctrl.ent.id   = entry_id_i;
    ctrl.ent.prio = entry_priority_i;
    ctrl.do_ins   = accept && ins_ok;
    ctrl.do_del   = accept && del_ok;
    unique case (cmd_i) inside
      CmdPushSorted:  ctrl.mode = SrchSorted;
      CmdPop, CmdTop: ctrl.mode = SrchHead;
      CmdRemove:      ctrl.mode = SrchId;
      default:        ctrl.mode = SrchTail;
    endcase
  end

  assign link[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent = ctrl.ent;
    end else begin : g_mid
      assign left_ent = ents[i-1];
    end

    // the tail cell refills from itself, that slot is then beyond the count
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_body
      assign right_ent = ents[i+1];
    end

    brq_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .left_i  (left_ent),
      .right_i (right_ent),
      .link_i  (link[i]),
      .link_o  (link[i+1]),
      .ent_o   (ents[i])
    );
  end

  // result and next fill level
  always_comb begin
    count_d  = count_q;
    status_d = StDone;
    res_d    = '0;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (del_ok) begin
      count_d = count_q - CntW'(1);
    end
    unique case (cmd_i) inside
      CmdPushTail, CmdPushSorted: begin
        if (full) status_d = StFull;
      end
      CmdPop, CmdTop: begin
        if (empty) status_d = StEmpty;
        else       res_d    = link[MAX_ENTRIES].ent;
      end
      CmdRemove: begin
        if (!link[MAX_ENTRIES].found) status_d = StEmpty;
        else                          res_d    = link[MAX_ENTRIES].ent;
      end
      default: begin
        status_d = StDone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapacityReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
      fill_q   <= 5'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_id_o       = res_q.id;
  assign out_priority_o = res_q.prio;
  assign fill_count_o   = fill_q;

  // fill level never passes the cell count
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("fill level beyond cell count");

  // an accepted insert that fits grows the fill level by one
  a_ins_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ins_ok) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow fill level");

  // a refused insert reports full and leaves the fill level alone
  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_ins && full) |=> (status_o == StFull && $stable(count_q)))
    else $error("refused insert changed state");

endmodule

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb - bounded ready queue core testbench
// Drives command items with random gaps and result stalls, predicts each
// result with a behavioral queue of its own and checks every returned field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import brq_pkg::*;

  localparam int Depth      = 16;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 70;
  localparam int NumPhases  = 7;

  // codes the block treats as no operation
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] id;
    logic [7:0] prio;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] id;
    logic [7:0] prio;
    logic [4:0] fill;
  } queue_result_t;

  // dut ports, all driven to known values from time zero
  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       cfg_we_i         = 1'b0;
  logic [4:0] cfg_wdata_i      = '0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic [2:0] cmd_i            = '0;
  logic [7:0] entry_id_i       = '0;
  logic [7:0] entry_priority_i = '0;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [1:0] status_o;
  logic [7:0] out_id_o;
  logic [7:0] out_priority_o;
  logic [4:0] fill_count_o;

  // items waiting to be sent and results waiting to come back
  cmd_item_t     pending_cmds[$];
  queue_result_t expected_results[$];

  // shadow copy of the queue contents and the capacity register
  logic [7:0] shadow_ids[Depth];
  logic [7:0] shadow_prios[Depth];
  int         shadow_count = 0;
  logic [4:0] shadow_capacity = CapacityReset;

  int  errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  take_stall = 0;
  bit  send_steady = 1'b0;
  bit  take_steady = 1'b0;

  bounded_ready_queue_core #(
    .MAX_ENTRIES(Depth)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .entry_id_i      (entry_id_i),
    .entry_priority_i(entry_priority_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_id_o        (out_id_o),
    .out_priority_o  (out_priority_o),
    .fill_count_o    (fill_count_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // queue predictor: applies one command to the shadow queue
  // ---------------------------------------------------------------------------
  function automatic queue_result_t apply_command(logic [2:0] cmd, logic [7:0] id,
                                                  logic [7:0] prio);
    queue_result_t res;
    int            limit;
    int            pos;
    res    = '{StDone, 8'd0, 8'd0, 5'd0};
    limit  = (shadow_capacity < Depth) ? int'(shadow_capacity) : Depth;
    case (cmd)
      CmdPushTail, CmdPushSorted: begin
        if (shadow_count >= limit) begin
          res.status = StFull;
        end else begin
          pos = shadow_count;
          if (cmd == CmdPushSorted) begin
            // walk past every entry with lower or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_prios[pos] <= prio) pos++;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_ids[i]   = shadow_ids[i-1];
            shadow_prios[i] = shadow_prios[i-1];
          end
          shadow_ids[pos]   = id;
          shadow_prios[pos] = prio;
          shadow_count++;
        end
      end
      CmdPop, CmdTop, CmdRemove: begin
        pos = 0;
        if (cmd == CmdRemove) begin
          while (pos < shadow_count && shadow_ids[pos] != id) pos++;
        end
        if (pos >= shadow_count) begin
          // empty queue or no matching id
          res.status = StEmpty;
        end else begin
          res.id   = shadow_ids[pos];
          res.prio = shadow_prios[pos];
          if (cmd != CmdTop) begin
            for (int i = pos; i + 1 < shadow_count; i++) begin
              shadow_ids[i]   = shadow_ids[i+1];
              shadow_prios[i] = shadow_prios[i+1];
            end
            shadow_count--;
          end
        end
      end
      default: ;  // count and spare codes only report the fill level
    endcase
    res.fill = 5'(shadow_count);
    return res;
  endfunction

  // idle span in cycles: mostly none or short, now and then long
  function automatic int idle_span(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: predicts on acceptance, then sends the next pending item
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    cmd_item_t nxt;
    bit        fire;
    fire = in_valid_i && in_ready_o;
    if (fire) begin
      expected_results.push_back(apply_command(cmd_i, entry_id_i, entry_priority_i));
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !fire) begin
      // item still waiting, hold valid and payload
    end else if (send_gap > 0) begin
      in_valid_i <= 1'b0;
      send_gap   <= send_gap - 1;
    end else if (pending_cmds.size() > 0) begin
      nxt              = pending_cmds.pop_front();
      cmd_i            <= nxt.cmd;
      entry_id_i       <= nxt.id;
      entry_priority_i <= nxt.prio;
      in_valid_i       <= 1'b1;
      // occasionally switch between gap-free stretches and random gaps
      if ($urandom_range(0, 99) < 4) send_steady <= ~send_steady;
      send_gap <= idle_span(send_steady);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result monitor: compares each taken result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    queue_result_t want;
    int            stall;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d id %0d prio %0d fill %0d",
                 $time, status_o, out_id_o, out_priority_o, fill_count_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("out_id", want.id, out_id_o);
        check_field("out_priority", want.prio, out_priority_o);
        check_field("fill_count", want.fill, fill_count_o);
      end
    end
    // back-pressure on the result side
    if (take_stall > 0) begin
      out_ready_i <= 1'b0;
      take_stall  <= take_stall - 1;
    end else begin
      stall = idle_span(take_steady);
      if ($urandom_range(0, 99) < 3) take_steady <= ~take_steady;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        take_stall  <= stall - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_item(logic [2:0] cmd, logic [7:0] id, logic [7:0] prio);
    pending_cmds.push_back('{cmd, id, prio});
  endtask

  // block is idle once every item is sent and every result is back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic set_capacity(logic [4:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    shadow_capacity = value;
    @(negedge clk_i);
  endtask

  // bursts of inserts alternate with bursts of pops and removes, so the
  // queue regularly fills up and drains; removes mostly name a live id
  task automatic random_phase(int n);
    logic [7:0] seen_ids[$];
    logic [2:0] cmd;
    logic [7:0] id;
    logic [7:0] prio;
    int         burst_left;
    bit         filling;
    int         r;
    burst_left = 0;
    filling    = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        filling    = ~filling;
        burst_left = $urandom_range(4, 24);
      end
      burst_left--;
      id   = 8'($urandom_range(0, 255));
      // narrow priorities give plenty of ties
      prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      r    = $urandom_range(0, 99);
      if (filling) begin
        if (r < 40)      cmd = CmdPushTail;
        else if (r < 80) cmd = CmdPushSorted;
        else if (r < 88) cmd = CmdTop;
        else if (r < 94) cmd = CmdCount;
        else             cmd = 3'($urandom_range(0, 7));
      end else begin
        if (r < 35)      cmd = CmdPop;
        else if (r < 70) cmd = CmdRemove;
        else if (r < 80) cmd = CmdTop;
        else if (r < 88) cmd = CmdPushSorted;
        else if (r < 92) cmd = CmdCount;
        else             cmd = 3'($urandom_range(0, 7));
      end
      if (cmd == CmdRemove && seen_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
        id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
      end
      if (cmd == CmdPushTail || cmd == CmdPushSorted) begin
        seen_ids.push_back(id);
        if (seen_ids.size() > 32) void'(seen_ids.pop_front());
      end
      add_item(cmd, id, prio);
    end
  endtask

  initial begin : main_proc
    logic [4:0] phase_caps[NumPhases];
    phase_caps = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd2, 5'd9, 5'd0};
    phase_caps[NumPhases-1] = 5'($urandom_range(0, 31));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue at the reset capacity, spare codes
    add_item(CmdPop, 8'h00, 8'h00);
    add_item(CmdTop, 8'hFF, 8'hFF);
    add_item(CmdRemove, 8'h00, 8'h00);
    add_item(CmdCount, 8'h00, 8'h00);
    add_item(CmdSpare6, 8'hFF, 8'hFF);
    add_item(CmdSpare7, 8'h00, 8'h00);
    // tail pushes ignore priority, sorted pushes keep ties in arrival order
    add_item(CmdPushTail, 8'h00, 8'hFF);
    add_item(CmdPushTail, 8'hFF, 8'h00);
    add_item(CmdPushSorted, 8'h5A, 8'h80);
    add_item(CmdPushSorted, 8'hA5, 8'h80);
    add_item(CmdPushSorted, 8'h11, 8'h00);
    add_item(CmdPushSorted, 8'h22, 8'hFF);
    add_item(CmdTop, 8'h00, 8'h00);
    add_item(CmdRemove, 8'hA5, 8'h00);
    add_item(CmdRemove, 8'h77, 8'h00);   // id not held
    add_item(CmdPop, 8'h00, 8'h00);
    wait_idle();

    // capacity dropped below the fill level: inserts refused until it drains
    set_capacity(5'd2);
    add_item(CmdPushTail, 8'h33, 8'h01);
    add_item(CmdPushSorted, 8'h44, 8'h02);
    add_item(CmdPop, 8'h00, 8'h00);
    add_item(CmdPop, 8'h00, 8'h00);
    add_item(CmdPushTail, 8'h55, 8'h10);
    add_item(CmdPushSorted, 8'h66, 8'h00);
    wait_idle();

    // capacity zero refuses every insert
    set_capacity(5'd0);
    add_item(CmdPushTail, 8'h77, 8'h00);
    add_item(CmdPop, 8'h00, 8'h00);
    add_item(CmdPop, 8'h00, 8'h00);

    // random phases, each under its own capacity
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      set_capacity(phase_caps[p]);
      random_phase(PhaseItems);
    end
    wait_idle();

    // results are registered, spare cycles at the end catch stray results
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
